[sv/s20_pkg.sv]
package s20_pkg;

  localparam int ROUND_COUNT_DEF = 20;
  localparam int WORD_COUNT      = 16;
  localparam int LANE_COUNT      = 4;

  typedef logic [31:0] word_t;
  typedef logic [WORD_COUNT-1:0][31:0] block_t;
  typedef logic [LANE_COUNT-1:0][31:0] lane_t;

  // "expand 32-byte k"
  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  localparam logic [5:0] BYTE_POS_LAST = 6'd63;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY_LOW    = 3'd0,
    REG_KEY_SECOND = 3'd1,
    REG_KEY_THIRD  = 3'd2,
    REG_KEY_HIGH   = 3'd3,
    REG_NONCE      = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    T_IDLE,
    T_BUILD
  } top_state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_LOAD,
    C_ROUND,
    C_FINAL,
    C_DONE
  } core_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  // Rotate amounts of the four quarter-round steps
  localparam logic [4:0] ROT_AMT [LANE_COUNT] = '{5'd7, 5'd9, 5'd13, 5'd18};

  // Word held at each lane slot (lane*4 + slot) for the column round
  localparam logic [3:0] COL_LAYOUT [WORD_COUNT] = '{
    4'd0,  4'd4,  4'd8,  4'd12,
    4'd5,  4'd9,  4'd13, 4'd1,
    4'd10, 4'd14, 4'd2,  4'd6,
    4'd15, 4'd3,  4'd7,  4'd11
  };

  // Word held at each lane slot for the row round
  localparam logic [3:0] ROW_LAYOUT [WORD_COUNT] = '{
    4'd0,  4'd1,  4'd2,  4'd3,
    4'd5,  4'd6,  4'd7,  4'd4,
    4'd10, 4'd11, 4'd8,  4'd9,
    4'd15, 4'd12, 4'd13, 4'd14
  };

  // Slot move between the two layouts; the same map serves both directions
  localparam logic [3:0] XPOSE [WORD_COUNT] = '{
    4'd0,  4'd7,  4'd10, 4'd13,
    4'd4,  4'd11, 4'd14, 4'd1,
    4'd8,  4'd15, 4'd2,  4'd5,
    4'd12, 4'd3,  4'd6,  4'd9
  };

  function automatic block_t build_init(input logic [63:0] k0, input logic [63:0] k1,
                                        input logic [63:0] k2, input logic [63:0] k3,
                                        input logic [63:0] nonce, input logic [63:0] ctr);
    block_t b;
    b[0]  = SIGMA0;
    b[1]  = k0[31:0];
    b[2]  = k0[63:32];
    b[3]  = k1[31:0];
    b[4]  = k1[63:32];
    b[5]  = SIGMA1;
    b[6]  = nonce[31:0];
    b[7]  = nonce[63:32];
    b[8]  = ctr[31:0];
    b[9]  = ctr[63:32];
    b[10] = SIGMA2;
    b[11] = k2[31:0];
    b[12] = k2[63:32];
    b[13] = k3[31:0];
    b[14] = k3[63:32];
    b[15] = SIGMA3;
    return b;
  endfunction

endpackage

[sv/s20_qr_unit.sv]
module s20_qr_unit import s20_pkg::*; (
  input  logic [1:0] step,
  input  lane_t      a,
  input  lane_t      b,
  input  lane_t      d,
  output lane_t      res
);

  lane_t                    sum;
  logic [LANE_COUNT-1:0][63:0] dbl;
  logic [4:0]               amt;

  // One quarter-round step on all four lanes: b ^ rotl(a + d, amt)
  always_comb begin
    amt = ROT_AMT[step];
    for (int k = 0; k < LANE_COUNT; k++) begin
      sum[k] = a[k] + d[k];
      dbl[k] = {sum[k], sum[k]} << amt;
      res[k] = b[k] ^ dbl[k][63:32];
    end
  end

endmodule

[sv/s20_core.sv]
module s20_core import s20_pkg::*; #(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  block_t     init,
  input  logic [5:0] byte_sel,
  output logic [7:0] ks_byte,
  output core_stat_t stat
);

  localparam int             RW         = $clog2(ROUND_COUNT);
  localparam logic [RW-1:0]  LAST_ROUND = RW'(ROUND_COUNT - 1);
  localparam logic           FINAL_ROW  = 1'(ROUND_COUNT % 2);

  core_state_t   state, state_next;
  logic [RW-1:0] round;
  logic [1:0]    step;
  block_t        q;
  block_t        ks;
  block_t        rot_q;
  block_t        perm_q;
  lane_t         lane_a, lane_b, lane_d, lane_res;

  // Lanes hold quarter-round tuples (a, b, c, d) in slots 0..3
  always_comb begin
    for (int k = 0; k < LANE_COUNT; k++) begin
      lane_a[k] = q[k*4 + 0];
      lane_b[k] = q[k*4 + 1];
      lane_d[k] = q[k*4 + 3];
    end
  end

  s20_qr_unit u_qr (
    .step (step),
    .a    (lane_a),
    .b    (lane_b),
    .d    (lane_d),
    .res  (lane_res)
  );

  // Rotate each tuple so the next step sees the same wiring; after four steps
  // the tuple is back in order and moves to the other round's layout
  always_comb begin
    for (int k = 0; k < LANE_COUNT; k++) begin
      rot_q[k*4 + 0] = lane_res[k];
      rot_q[k*4 + 1] = q[k*4 + 2];
      rot_q[k*4 + 2] = q[k*4 + 3];
      rot_q[k*4 + 3] = q[k*4 + 0];
    end
    for (int p = 0; p < WORD_COUNT; p++) begin
      perm_q[p] = rot_q[XPOSE[p]];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE:  if (start) state_next = C_LOAD;
      C_LOAD:  state_next = C_ROUND;
      C_ROUND: if (step == 2'd3 && round == LAST_ROUND) state_next = C_FINAL;
      C_FINAL: state_next = C_DONE;
      C_DONE:  state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  // Status
  always_comb begin
    stat.busy = (state != C_IDLE);
    stat.done = (state == C_DONE);
  end

  // Sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      round <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == C_LOAD) begin
        round <= '0;
        step  <= '0;
      end else if (state == C_ROUND) begin
        step <= step + 2'd1;
        if (step == 2'd3) round <= round + RW'(1);
      end
    end
  end

  // Working words and keystream store
  always_ff @(posedge clk) begin
    unique case (state)
      C_LOAD: begin
        for (int p = 0; p < WORD_COUNT; p++) q[p] <= init[COL_LAYOUT[p]];
      end
      C_ROUND: begin
        q <= (step == 2'd3) ? perm_q : rot_q;
      end
      C_FINAL: begin
        for (int p = 0; p < WORD_COUNT; p++) begin
          if (FINAL_ROW) ks[ROW_LAYOUT[p]] <= q[p] + init[ROW_LAYOUT[p]];
          else           ks[COL_LAYOUT[p]] <= q[p] + init[COL_LAYOUT[p]];
        end
      end
      default: begin
      end
    endcase
  end

  // Little-endian byte pick
  assign ks_byte = ks[byte_sel[5:2]][{byte_sel[1:0], 3'b000} +: 8];

endmodule

[sv/salsa20_stream_cipher_top.sv]
// Channel   | Handshake           | Payload
// ----------+---------------------+---------------------------------------
// input     | in_valid / in_stall | data_byte[7:0], first_of_message
// output    | out_valid/out_stall | cipher_byte[7:0]
// config    | cfg_write           | cfg_index[2:0], cfg_data[63:0]
//
// A byte inside a 64-byte block is taken on accept and its result goes to the output register.
// The first byte of a block starts the core, which loads, runs every round step on the shared
// quarter-round step unit, adds the input back in and signals done; the result is then registered.
// Reset is synchronous; it clears key, nonce, block counter and byte position.
// in_stall is high while a block is built or a result waits in the output register.
module salsa20_stream_cipher_top import s20_pkg::*; #(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  cipher_byte,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  top_state_t  state, state_next;
  logic [63:0] key_low_quarter, key_second_quarter, key_third_quarter, key_high_quarter;
  logic [63:0] nonce_value;
  logic [63:0] block_counter;
  logic [5:0]  byte_position;
  logic [63:0] blk_ctr;
  logic [7:0]  held_byte;
  logic        accept;
  logic        start;
  logic [5:0]  pos_eff;
  logic [63:0] ctr_eff;
  logic [5:0]  ks_sel;
  logic [7:0]  ks_byte;
  block_t      init;
  core_stat_t  core_stat;

  // A first-of-message byte restarts counter and position
  assign pos_eff = first_of_message ? '0 : byte_position;
  assign ctr_eff = first_of_message ? '0 : block_counter;
  assign accept  = in_valid && !in_stall;
  assign ks_sel  = (state == T_BUILD) ? '0 : pos_eff;
  assign init    = build_init(key_low_quarter, key_second_quarter, key_third_quarter,
                              key_high_quarter, nonce_value, blk_ctr);

  s20_core #(.ROUND_COUNT(ROUND_COUNT)) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .init     (init),
    .byte_sel (ks_sel),
    .ks_byte  (ks_byte),
    .stat     (core_stat)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  if (accept && pos_eff == '0) state_next = T_BUILD;
      T_BUILD: if (core_stat.done) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // Handshake and core start
  always_comb begin
    in_stall = (state != T_IDLE) || out_valid;
    start    = accept && (pos_eff == '0);
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= T_IDLE;
      out_valid          <= 1'b0;
      block_counter      <= '0;
      byte_position      <= '0;
      key_low_quarter    <= '0;
      key_second_quarter <= '0;
      key_third_quarter  <= '0;
      key_high_quarter   <= '0;
      nonce_value        <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_KEY_LOW:    key_low_quarter    <= cfg_data;
          REG_KEY_SECOND: key_second_quarter <= cfg_data;
          REG_KEY_THIRD:  key_third_quarter  <= cfg_data;
          REG_KEY_HIGH:   key_high_quarter   <= cfg_data;
          REG_NONCE:      nonce_value        <= cfg_data;
          default: begin
          end
        endcase
      end
      // Advance position; bump the counter when the block wraps
      if (accept) begin
        byte_position <= pos_eff + 6'd1;
        block_counter <= (pos_eff == BYTE_POS_LAST) ? ctr_eff + 64'd1 : ctr_eff;
      end
      // Drop a taken result, raise a new one
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if ((accept && !start) || core_stat.done) out_valid <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start) begin
      held_byte <= data_byte;
      blk_ctr   <= ctr_eff;
    end
    if (accept && !start) cipher_byte <= data_byte ^ ks_byte;
    else if (core_stat.done) cipher_byte <= held_byte ^ ks_byte;
  end

endmodule

[sv/s20_checker.sv]
module s20_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] cipher_byte
);

  // Hold off input while a result waits
  a_stall_on_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result waits");

  // One byte at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction taken before the first finished");

  // A taken result is not followed at once by another
  a_no_back_to_back_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result shown again right after a transaction");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(cipher_byte)))
    else $error("stalled result changed");

endmodule

bind salsa20_stream_cipher_top s20_checker u_s20_checker (.*);

[sim/tb.sv]
`timescale 1ns / 100ps
module tb;
  import s20_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASES       = 9;
  // first register index with no register behind it
  localparam logic [2:0] REG_SPARE = 3'd5;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        first_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  cipher_byte;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [63:0] cfg_data = 64'd0;

  // stimulus control shared with the receiver side
  logic calm = 1'b0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  int mismatch_count = 0;
  int result_count = 0;
  int quiet_cycles = 0;

  // cipher model state
  logic [63:0] key_q [4] = '{default: 64'd0};
  logic [63:0] nonce_q = 64'd0;
  logic [63:0] block_ctr = 64'd0;
  logic [5:0]  byte_pos = 6'd0;
  block_t      ks_block;
  logic [7:0]  cipher_due [$];

  // directed bytes: extremes, restarts mid-block and back to back
  byte_req_t dir_tab [20] = '{
    '{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{8'hAA, 1'b0}, '{8'h55, 1'b0},
    '{8'h01, 1'b0}, '{8'h80, 1'b0}, '{8'hFE, 1'b0}, '{8'h7F, 1'b0},
    '{8'h00, 1'b1}, '{8'hFF, 1'b0}, '{8'h0F, 1'b0}, '{8'hF0, 1'b0},
    '{8'h00, 1'b1}, '{8'h00, 1'b1}, '{8'h5A, 1'b0}, '{8'hA5, 1'b0},
    '{8'h3C, 1'b0}, '{8'hC3, 1'b0}, '{8'hFF, 1'b1}, '{8'h00, 1'b0}
  };

  salsa20_stream_cipher_top u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .first_of_message (first_of_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .cipher_byte      (cipher_byte),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic word_t rotl(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic block_t quarter(block_t w, int a, int b, int c, int d);
    w[b] = w[b] ^ rotl(w[a] + w[d], 7);
    w[c] = w[c] ^ rotl(w[b] + w[a], 9);
    w[d] = w[d] ^ rotl(w[c] + w[b], 13);
    w[a] = w[a] ^ rotl(w[d] + w[c], 18);
    return w;
  endfunction

  // Run the column/row rounds and add the input back in
  function automatic block_t salsa_core(block_t init);
    block_t w;
    w = init;
    for (int r = 0; r < ROUND_COUNT_DEF; r++) begin
      if (r % 2 == 0) begin
        w = quarter(w, 0, 4, 8, 12);
        w = quarter(w, 5, 9, 13, 1);
        w = quarter(w, 10, 14, 2, 6);
        w = quarter(w, 15, 3, 7, 11);
      end else begin
        w = quarter(w, 0, 1, 2, 3);
        w = quarter(w, 5, 6, 7, 4);
        w = quarter(w, 10, 11, 8, 9);
        w = quarter(w, 15, 12, 13, 14);
      end
    end
    for (int i = 0; i < 16; i++) w[i] = w[i] + init[i];
    return w;
  endfunction

  // Advance the cipher model by one byte and return the expected cipher byte
  function automatic logic [7:0] encipher_byte(logic [7:0] d, logic f);
    block_t     init;
    word_t      ks_word;
    logic [7:0] c;
    if (f) begin
      block_ctr = 64'd0;
      byte_pos = 6'd0;
    end
    if (byte_pos == 6'd0) begin
      init[0]  = SIGMA0;
      init[1]  = key_q[0][31:0];
      init[2]  = key_q[0][63:32];
      init[3]  = key_q[1][31:0];
      init[4]  = key_q[1][63:32];
      init[5]  = SIGMA1;
      init[6]  = nonce_q[31:0];
      init[7]  = nonce_q[63:32];
      init[8]  = block_ctr[31:0];
      init[9]  = block_ctr[63:32];
      init[10] = SIGMA2;
      init[11] = key_q[2][31:0];
      init[12] = key_q[2][63:32];
      init[13] = key_q[3][31:0];
      init[14] = key_q[3][63:32];
      init[15] = SIGMA3;
      ks_block = salsa_core(init);
    end
    ks_word = ks_block[byte_pos[5:2]];
    c = d ^ ks_word[8 * byte_pos[1:0] +: 8];
    byte_pos = byte_pos + 6'd1;
    if (byte_pos == 6'd0) block_ctr = block_ctr + 64'd1;
    return c;
  endfunction

  function automatic logic [63:0] pick_value(int p);
    case (p)
      1: return '1;
      2: return '0;
      3: return 64'hA5A5_A5A5_A5A5_A5A5;
      4: return 64'h5A5A_5A5A_5A5A_5A5A;
      default: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          default: return {$urandom, $urandom};
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 100) $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Write one register; the caller drops cfg_write after the last write
  task automatic set_reg(logic [2:0] idx, logic [63:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_KEY_LOW:    key_q[0] = v;
      REG_KEY_SECOND: key_q[1] = v;
      REG_KEY_THIRD:  key_q[2] = v;
      REG_KEY_HIGH:   key_q[3] = v;
      REG_NONCE:      nonce_q = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one byte, hold it until accepted, then record the expected result
  task automatic push_byte(logic [7:0] d, logic f);
    if (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    first_of_message <= f;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    cipher_due.push_back(encipher_byte(d, f));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (cipher_due.size() != 0) @(posedge clk);
  endtask

  // Receiver stall: random, calm stretch, and one long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 13);
    end
  end

  // Compare each result transaction with the oldest expected byte
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (cipher_due.size() == 0) begin
        report_mismatch($sformatf("unexpected cipher_byte %02h", cipher_byte));
      end else begin
        if (cipher_byte !== cipher_due[0])
          report_mismatch($sformatf("result %0d cipher_byte %02h, want %02h",
                                    result_count, cipher_byte, cipher_due[0]));
        void'(cipher_due.pop_front());
      end
      result_count++;
    end
  end

  // Stop a hung run: count cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed bytes under the reset key and nonce
    foreach (dir_tab[i]) push_byte(dir_tab[i].data, dir_tab[i].first);
    drain();

    for (int p = 1; p < PHASES; p++) begin
      // rewrite every register while idle, plus an index with nothing behind it
      set_reg(REG_KEY_LOW, pick_value(p));
      set_reg(REG_KEY_SECOND, pick_value(p));
      set_reg(REG_KEY_THIRD, pick_value(p));
      set_reg(REG_KEY_HIGH, pick_value(p));
      set_reg(REG_NONCE, pick_value(p));
      set_reg(3'(REG_SPARE + $urandom_range(2)), {$urandom, $urandom});
      cfg_write <= 1'b0;
      calm <= (p == 2);
      hold_go <= (p == 5);

      if (p == 1) begin
        // continue the directed message: the open block keeps its keystream
        for (n = 0; n < 130; n++) push_byte(8'($urandom), 1'b0);
      end else begin
        // messages of random length, with a few stray restarts and headless ones
        n = 0;
        while (n < 200) begin
          len = ($urandom_range(7) == 0) ? $urandom_range(65, 300) : $urandom_range(1, 140);
          for (int i = 0; i < len; i++)
            push_byte(8'($urandom),
                      (i == 0 && $urandom_range(7) != 0) || $urandom_range(49) == 0);
          n += len;
        end
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && cipher_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
